FILE: hw/rtl/lcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lcs_pkg;

   // Fixed field widths
   localparam int GRID_W = 11;
   localparam int POS_W  = 10;

   // Defaults for the top-level parameters
   localparam int MAX_GRID_DEFAULT    = 1024;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Grid size after reset, and the smallest grid size allowed
   localparam int GRID_RESET = 10;
   localparam int GRID_MIN   = 3;

   // Response slots a single request can produce, in emission order
   localparam int NUM_SLOTS = 4;
   localparam logic [1:0] SLOT_BODY     = 2'd0;  // (r-1, c-1)
   localparam logic [1:0] SLOT_ROW_END  = 2'd1;  // (r-1, N-1)
   localparam logic [1:0] SLOT_LAST_ROW = 2'd2;  // (N-1, c-1)
   localparam logic [1:0] SLOT_CORNER   = 2'd3;  // (N-1, N-1)

   // One queued request: which responses it makes and their data
   typedef struct packed {
      logic [NUM_SLOTS-1:0] mask;
      logic [NUM_SLOTS-1:0] value;
      logic [POS_W-1:0]     row_m1;
      logic [POS_W-1:0]     col_m1;
      logic [POS_W-1:0]     last;
   } lcs_rec_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic        not_empty;
      lcs_rec_type head;
   } lcs_head_type;

   // Last index (N-1) for a written grid size, clamped to [GRID_MIN, maxg]
   function automatic int lcs_last(input int g, input int maxg);
      int n;
      n = g;
      if (n < GRID_MIN) n = GRID_MIN;
      if (n > maxg) n = maxg;
      return n - 1;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/life_cell_stencil_core.sv
// Channel    Direction  Handshake             Payload
// req_       in         req_valid/req_stall   req_cell_in
// rsp_       out        rsp_valid/rsp_stall   rsp_out_row, rsp_out_col, rsp_cell_out,
//                                             rsp_run_last
// csr_       in         csr_write_en          csr_grid_size
//
// One request per cycle while each request makes at most one response and
// rsp_stall is low; the response register drains one per cycle unless stalled,
// so a row end (two responses) and the last row (up to four) hold requests
// back through the request queue. A request goes through line-store read,
// classify and enqueue, and expand before it reaches the response register.
// Reset is synchronous; the line stores are not cleared, since no response
// depends on an entry that its own frame has not yet written.
`timescale 1ns / 1ps
`default_nettype none

module life_cell_stencil_core
   import lcs_pkg::*;
#(
   parameter int MAX_GRID    = MAX_GRID_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_en,
   input  wire logic [GRID_W-1:0]  csr_grid_size,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_cell_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [POS_W-1:0]        rsp_out_row,
   output logic [POS_W-1:0]        rsp_out_col,
   output logic                    rsp_cell_out,
   output logic                    rsp_run_last
);

   logic                             q_push;
   logic                             q_pop;
   lcs_rec_type                      q_rec;
   lcs_head_type                     q_head;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

   // position, line stores, window and rule
   lcs_front #(
      .MAX_GRID    (MAX_GRID),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_grid_size (csr_grid_size),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cell_in   (req_cell_in),
      .q_count       (q_count),
      .q_push        (q_push),
      .q_rec         (q_rec)
   );

   // decoupling queue
   lcs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (q_rec),
      .pop      (q_pop),
      .head     (q_head),
      .count    (q_count)
   );

   // response expansion
   lcs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_row  (rsp_out_row),
      .rsp_out_col  (rsp_out_col),
      .rsp_cell_out (rsp_cell_out),
      .rsp_run_last (rsp_run_last)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/lcs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lcs_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/lcs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lcs_front
   import lcs_pkg::*;
#(
   parameter int MAX_GRID    = MAX_GRID_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_en,
   input  wire logic [GRID_W-1:0]                  csr_grid_size,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_cell_in,
   input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_count,
   output logic                                    q_push,
   output lcs_rec_type                             q_rec
);

   localparam int AW = $clog2(MAX_GRID);
   localparam int CW = $clog2(QUEUE_DEPTH+1);
   localparam logic [AW-1:0] LAST_RESET = AW'(lcs_last(GRID_RESET, MAX_GRID));

   logic [AW-1:0] last_ff;
   logic [AW-1:0] row_ff, row_in;
   logic [AW-1:0] col_ff, col_in;
   logic          s1_valid_ff;
   logic [AW-1:0] s1_row_ff;
   logic [AW-1:0] s1_col_ff;
   logic          s1_bit_ff;
   logic [8:0]    window_ff, window_in;
   logic [1:0]    line_rd;
   logic [CW:0]   q_need;
   logic          accept;
   logic [3:0]    count;
   logic          rule;
   logic          r_ge1, r_ge2, c_ge1, c_ge2, c_last, r_last;

   // stall while the queue might not hold the request already in flight
   assign q_need    = {1'b0, q_count} + (CW+1)'(s1_valid_ff);
   assign req_stall = (q_need >= (CW+1)'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   // raster position of the next request
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (col_ff == last_ff) begin
            col_in = '0;
            row_in = (row_ff == last_ff) ? '0 : row_ff + AW'(1);
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   // size register and counters; a size write restarts the frame
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff     <= LAST_RESET;
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (csr_write_en) begin
            last_ff <= AW'(lcs_last(int'(csr_grid_size), MAX_GRID));
            row_ff  <= '0;
            col_ff  <= '0;
         end else begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
      end
   end

   // request payload is registered alongside the line-store read
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_row_ff <= row_ff;
         s1_col_ff <= col_ff;
         s1_bit_ff <= req_cell_in;
      end
   end

   // two line stores packed side by side: bit 1 row r-1, bit 0 row r-2
   lcs_ram #(
      .WIDTH (2),
      .DEPTH (MAX_GRID)
   ) u_lines (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data ({s1_bit_ff, line_rd[1]}),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (line_rd)
   );

   // 3x3 window shift: newest column enters at the top bits
   assign window_in = {s1_bit_ff, line_rd, window_ff[8:3]};

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (s1_valid_ff) begin
         window_ff <= window_in;
      end
   end

   // neighbor count without the center, then B3/S23
   always_comb begin
      count = '0;
      for (int i = 0; i < 9; i++) begin
         if (i != 4) begin
            count = count + 4'(window_in[i]);
         end
      end
      rule = (count == 4'd3) || ((count == 4'd2) && window_in[4]);
   end

   // classify the request into its response slots
   always_comb begin
      r_ge1  = (s1_row_ff != '0);
      r_ge2  = (s1_row_ff > AW'(1));
      c_ge1  = (s1_col_ff != '0);
      c_ge2  = (s1_col_ff > AW'(1));
      c_last = (s1_col_ff == last_ff);
      r_last = (s1_row_ff == last_ff);

      q_rec = '0;
      q_rec.mask[SLOT_BODY]      = r_ge1 && c_ge1;
      q_rec.mask[SLOT_ROW_END]   = r_ge1 && c_last;
      q_rec.mask[SLOT_LAST_ROW]  = r_ge1 && r_last && c_ge1;
      q_rec.mask[SLOT_CORNER]    = r_ge1 && r_last && c_last;
      q_rec.value[SLOT_BODY]     = (r_ge2 && c_ge2) ? rule : window_in[4];
      q_rec.value[SLOT_ROW_END]  = window_in[7];
      q_rec.value[SLOT_LAST_ROW] = window_in[5];
      q_rec.value[SLOT_CORNER]   = window_in[8];
      q_rec.row_m1 = POS_W'(s1_row_ff - AW'(1));
      q_rec.col_m1 = POS_W'(s1_col_ff - AW'(1));
      q_rec.last   = POS_W'(last_ff);

      q_push = s1_valid_ff && (q_rec.mask != '0);
   end

endmodule

`default_nettype wire

FILE: hw/rtl/lcs_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module lcs_queue
   import lcs_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  lcs_rec_type                       push_rec,
   input  wire logic                         pop,
   output lcs_head_type                      head,
   output logic [$clog2(DEPTH+1)-1:0]        count
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   lcs_rec_type   slots_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_pop;

   assign do_pop          = pop && (count_ff != '0);
   assign head.not_empty  = (count_ff != '0);
   assign head.head       = slots_ff[rd_ptr_ff];
   assign count           = count_ff;

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         count_ff <= count_ff + CW'(push) - CW'(do_pop);
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/lcs_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lcs_back
   import lcs_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  lcs_head_type            q_head,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [POS_W-1:0]        rsp_out_row,
   output logic [POS_W-1:0]        rsp_out_col,
   output logic                    rsp_cell_out,
   output logic                    rsp_run_last
);

   lcs_rec_type          work_ff, work_in;
   logic                 work_valid_ff, work_valid_in;
   logic                 rsp_valid_ff;
   logic [POS_W-1:0]     row_ff, col_ff;
   logic                 cell_ff, run_last_ff;
   logic                 out_free, emit, done;
   logic [1:0]           sel;
   logic [NUM_SLOTS-1:0] rest;
   logic [POS_W-1:0]     sel_row, sel_col;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = work_valid_ff && out_free;

   // pick the lowest pending slot
   always_comb begin
      if (work_ff.mask[SLOT_BODY]) begin
         sel = SLOT_BODY;
      end else if (work_ff.mask[SLOT_ROW_END]) begin
         sel = SLOT_ROW_END;
      end else if (work_ff.mask[SLOT_LAST_ROW]) begin
         sel = SLOT_LAST_ROW;
      end else begin
         sel = SLOT_CORNER;
      end
      rest      = work_ff.mask;
      rest[sel] = 1'b0;
      done      = (rest == '0);

      case (sel)
         SLOT_BODY: begin
            sel_row = work_ff.row_m1;
            sel_col = work_ff.col_m1;
         end
         SLOT_ROW_END: begin
            sel_row = work_ff.row_m1;
            sel_col = work_ff.last;
         end
         SLOT_LAST_ROW: begin
            sel_row = work_ff.last;
            sel_col = work_ff.col_m1;
         end
         default: begin
            sel_row = work_ff.last;
            sel_col = work_ff.last;
         end
      endcase
   end

   // load the next queued request when idle or as the current one finishes
   always_comb begin
      q_pop         = q_head.not_empty && (!work_valid_ff || (emit && done));
      work_in       = work_ff;
      work_valid_in = work_valid_ff;
      if (q_pop) begin
         work_in       = q_head.head;
         work_valid_in = 1'b1;
      end else if (emit) begin
         work_in.mask  = rest;
         work_valid_in = !done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_free) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (emit) begin
         row_ff      <= sel_row;
         col_ff      <= sel_col;
         cell_ff     <= work_ff.value[sel];
         run_last_ff <= done;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_row  = row_ff;
   assign rsp_out_col  = col_ff;
   assign rsp_cell_out = cell_ff;
   assign rsp_run_last = run_last_ff;

endmodule

`default_nettype wire
